// File: hdl/greedy_box_nms_macros.svh
// Assertion macros for the greedy box suppression block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef GREEDY_BOX_NMS_MACROS_SVH
`define GREEDY_BOX_NMS_MACROS_SVH

// check consequent in the same cycle
`define GBN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gbn assertion failed");

// check consequent in the next cycle
`define GBN_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gbn assertion failed");

`endif

// File: hdl/gbn_pkg.sv
// Shared constants and control structs for the greedy box suppression block.
// No dependencies.
package gbn_pkg;

  localparam int MAX_KEPT_DEF   = 64;
  localparam int COORD_BITS_DEF = 16;
  localparam int THR_W          = 9;
  localparam logic [THR_W-1:0] THR_RESET = 9'd102;
  localparam int KT_W           = 7;
  localparam int Q_SHIFT        = 8;

  typedef struct packed {
    logic shift;
    logic load;
  } chain_ctl_t;

  typedef struct packed {
    logic busy;
    logic hit;
  } iou_stat_t;

endpackage

// File: hdl/gbn_ifs.sv
// Handshake interfaces for box items, result items and threshold writes.
// Depends on gbn_pkg.
interface gbn_in_if import gbn_pkg::*; #(parameter int COORD_BITS = COORD_BITS_DEF) ();
  logic                         valid;
  logic                         ready;
  logic                         first_box;
  logic signed [COORD_BITS-1:0] box_x;
  logic signed [COORD_BITS-1:0] box_y;
  logic        [COORD_BITS-2:0] box_w;
  logic        [COORD_BITS-2:0] box_h;
  modport source (output valid, first_box, box_x, box_y, box_w, box_h, input ready);
  modport sink   (input valid, first_box, box_x, box_y, box_w, box_h, output ready);
endinterface

interface gbn_out_if import gbn_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            keep;
  logic [KT_W-1:0] kept_total;
  logic            store_overflow;
  modport source (output valid, keep, kept_total, store_overflow, input ready);
  modport sink   (input valid, keep, kept_total, store_overflow, output ready);
endinterface

interface gbn_cfg_if import gbn_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [THR_W-1:0] iou_threshold;
  modport source (output valid, iou_threshold, input ready);
  modport sink   (input valid, iou_threshold, output ready);
endinterface

// File: hdl/gbn_slot.sv
// One stage of the kept-box ring: holds one box, loads or takes its neighbor.
// Depends on gbn_pkg.
module gbn_slot import gbn_pkg::*; #(
  parameter int BOX_W = 4 * COORD_BITS_DEF - 2
) (
  input  logic             clk,
  input  logic             shift_en,
  input  logic             load_en,
  input  logic [BOX_W-1:0] nbr_in,
  input  logic [BOX_W-1:0] load_in,
  output logic [BOX_W-1:0] box_q
);

  logic [BOX_W-1:0] box_r;
  logic [BOX_W-1:0] box_nxt;

  always_comb begin
    box_nxt = box_r;
    if (load_en) begin
      box_nxt = load_in;
    end else if (shift_en) begin
      box_nxt = nbr_in;
    end
  end

  always_ff @(posedge clk) begin
    box_r <= box_nxt;
  end

  assign box_q = box_r;

endmodule

// File: hdl/gbn_chain.sv
// Ring of kept-box slots that rotates one place per cycle toward slot 0 while ctl.shift is set.
// Depends on gbn_pkg and gbn_slot.
module gbn_chain import gbn_pkg::*; #(
  parameter int MAX_KEPT = MAX_KEPT_DEF,
  parameter int BOX_W    = 4 * COORD_BITS_DEF - 2,
  parameter int CW       = $clog2(MAX_KEPT_DEF + 1)
) (
  input  logic             clk,
  input  chain_ctl_t       ctl,
  input  logic [CW-1:0]    load_idx,
  input  logic [BOX_W-1:0] load_box,
  output logic [BOX_W-1:0] head_box
);

  logic [BOX_W-1:0] slot_q [MAX_KEPT];

  for (genvar i = 0; i < MAX_KEPT; i++) begin : g_slot
    gbn_slot #(.BOX_W(BOX_W)) u_slot (
      .clk      (clk),
      .shift_en (ctl.shift),
      .load_en  (ctl.load && (load_idx == CW'(i))),
      .nbr_in   (slot_q[(i + 1) % MAX_KEPT]),
      .load_in  (load_box),
      .box_q    (slot_q[i])
    );
  end

  assign head_box = slot_q[0];

endmodule

// File: hdl/gbn_iou.sv
// Five-stage overlap test of one box pair: intersection, areas, union,
// threshold product and compare. Depends on gbn_pkg.
module gbn_iou import gbn_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        issue,
  input  logic [4*COORD_BITS-3:0]     cur_box,
  input  logic [4*COORD_BITS-3:0]     kept_box,
  input  logic [THR_W-1:0]            thr,
  output iou_stat_t                   stat
);

  localparam int W  = COORD_BITS;
  localparam int S  = COORD_BITS - 1;
  localparam int AW = 2 * S;
  localparam int UW = AW + 1;
  localparam int LW = AW + Q_SHIFT;
  localparam int RW = UW + THR_W;

  logic signed [W-1:0] ax, ay, bx, by;
  logic        [S-1:0] aw, ah, bw, bh;
  logic signed [W-1:0] x0, y0;
  logic signed [W:0]   x1, y1, ax1, bx1, ay1, by1;
  logic signed [W+1:0] dx, dy;
  logic        [S-1:0] iw_nxt, ih_nxt;

  logic          v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [S-1:0]  iw_r, ih_r, aw_r, ah_r, bw_r, bh_r;
  logic [AW-1:0] inter_r, ak_r, bk_r;
  logic [UW-1:0] uni_r;
  logic [LW-1:0] lhs3_r, lhs4_r;
  logic [RW-1:0] rhs_r;
  logic          hit_r;

  assign ax = cur_box[4*W-3 -: W];
  assign ay = cur_box[3*W-3 -: W];
  assign aw = cur_box[2*W-3 -: S];
  assign ah = cur_box[S-1:0];
  assign bx = kept_box[4*W-3 -: W];
  assign by = kept_box[3*W-3 -: W];
  assign bw = kept_box[2*W-3 -: S];
  assign bh = kept_box[S-1:0];

  always_comb begin
    ax1 = $signed({ax[W-1], ax}) + $signed({2'b00, aw});
    bx1 = $signed({bx[W-1], bx}) + $signed({2'b00, bw});
    ay1 = $signed({ay[W-1], ay}) + $signed({2'b00, ah});
    by1 = $signed({by[W-1], by}) + $signed({2'b00, bh});
    x0  = (ax > bx) ? ax : bx;
    y0  = (ay > by) ? ay : by;
    x1  = (ax1 < bx1) ? ax1 : bx1;
    y1  = (ay1 < by1) ? ay1 : by1;
    dx  = $signed({x1[W], x1}) - $signed({{2{x0[W-1]}}, x0});
    dy  = $signed({y1[W], y1}) - $signed({{2{y0[W-1]}}, y0});
    iw_nxt = (dx > 0) ? dx[S-1:0] : '0;
    ih_nxt = (dy > 0) ? dy[S-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
    iw_r    <= iw_nxt;
    ih_r    <= ih_nxt;
    aw_r    <= aw;
    ah_r    <= ah;
    bw_r    <= bw;
    bh_r    <= bh;
    inter_r <= AW'(iw_r) * AW'(ih_r);
    ak_r    <= AW'(aw_r) * AW'(ah_r);
    bk_r    <= AW'(bw_r) * AW'(bh_r);
    uni_r   <= UW'(ak_r) + UW'(bk_r) - UW'(inter_r);
    lhs3_r  <= {inter_r, {Q_SHIFT{1'b0}}};
    rhs_r   <= RW'(thr) * RW'(uni_r);
    lhs4_r  <= lhs3_r;
    hit_r   <= RW'(lhs4_r) > rhs_r;
  end

  assign stat.busy = v1_r | v2_r | v3_r | v4_r | v5_r;
  assign stat.hit  = v5_r & hit_r;

endmodule

// File: hdl/greedy_box_nms.sv
// Greedy box suppression: each item is tested against every kept box as the
// kept ring rotates once past one pipelined overlap unit.
// A new item is accepted only in idle, after the previous item's rotation,
// pipe drain and result hand-off are through.
// Reset: synchronous active-low rst_n empties the kept list and sets the
// threshold to 102; kept boxes themselves are not cleared.
`include "greedy_box_nms_macros.svh"

module greedy_box_nms import gbn_pkg::*; #(
  parameter int MAX_KEPT   = MAX_KEPT_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  gbn_in_if.sink    in_if,
  gbn_out_if.source out_if,
  gbn_cfg_if.sink   cfg_if
);

  localparam int BOX_W = 4 * COORD_BITS - 2;
  localparam int CW    = $clog2(MAX_KEPT + 1);
  localparam int SW    = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_DONE} state_t;

  state_t           state_r, state_nxt;
  logic [SW-1:0]    step_r, step_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [BOX_W-1:0] cur_r, cur_nxt;
  logic             susp_r, susp_nxt;
  logic [THR_W-1:0] thr_r, thr_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             keep_r, keep_nxt;
  logic [KT_W-1:0]  total_r, total_nxt;
  logic             ovf_r, ovf_nxt;

  logic             issue;
  logic             keep_now;
  chain_ctl_t       ctl;
  iou_stat_t        stat;
  logic [BOX_W-1:0] head_box;

  gbn_chain #(.MAX_KEPT(MAX_KEPT), .BOX_W(BOX_W), .CW(CW)) u_chain (
    .clk      (clk),
    .ctl      (ctl),
    .load_idx (count_r),
    .load_box (cur_r),
    .head_box (head_box)
  );

  gbn_iou #(.COORD_BITS(COORD_BITS)) u_iou (
    .clk      (clk),
    .rst_n    (rst_n),
    .issue    (issue),
    .cur_box  (cur_r),
    .kept_box (head_box),
    .thr      (thr_r),
    .stat     (stat)
  );

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    count_nxt     = count_r;
    cur_nxt       = cur_r;
    susp_nxt      = susp_r | stat.hit;
    thr_nxt       = thr_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    keep_nxt      = keep_r;
    total_nxt     = total_r;
    ovf_nxt       = ovf_r;
    issue         = 1'b0;
    keep_now      = !susp_r;
    ctl           = '0;

    if (cfg_if.valid) begin
      thr_nxt = cfg_if.iou_threshold;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          cur_nxt  = {in_if.box_x, in_if.box_y, in_if.box_w, in_if.box_h};
          susp_nxt = 1'b0;
          step_nxt = '0;
          if (in_if.first_box) begin
            count_nxt = '0;
          end
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        issue     = CW'(step_r) < count_r;
        ctl.shift = 1'b1;
        step_nxt  = step_r + 1'b1;
        if (step_r == SW'(MAX_KEPT - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          keep_nxt      = keep_now;
          ovf_nxt       = keep_now && (count_r == CW'(MAX_KEPT));
          if (keep_now && (count_r < CW'(MAX_KEPT))) begin
            ctl.load  = 1'b1;
            count_nxt = count_r + 1'b1;
          end
          total_nxt = KT_W'(count_nxt);
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      count_r     <= '0;
      susp_r      <= 1'b0;
      thr_r       <= THR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      count_r     <= count_nxt;
      susp_r      <= susp_nxt;
      thr_r       <= thr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r   <= cur_nxt;
    keep_r  <= keep_nxt;
    total_r <= total_nxt;
    ovf_r   <= ovf_nxt;
  end

  assign in_if.ready           = (state_r == ST_IDLE);
  assign cfg_if.ready          = 1'b1;
  assign out_if.valid          = out_valid_r;
  assign out_if.keep           = keep_r;
  assign out_if.kept_total     = total_r;
  assign out_if.store_overflow = ovf_r;

  `GBN_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CW'(MAX_KEPT))
  `GBN_ASSERT_IMP(a_ovf_full, out_valid_r && ovf_r, keep_r && (total_r == KT_W'(MAX_KEPT)))
  `GBN_ASSERT_IMP(a_rose_from_done, $rose(out_valid_r), $past(state_r == ST_DONE))
  `GBN_ASSERT_IMP(a_idle_drained, state_r == ST_IDLE, !stat.busy)

endmodule
